// ----- sv/utm_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 text width block.
`default_nettype none

package utm_pkg;

   localparam int ByteW   = 8;
   localparam int CpW     = 21;
   localparam int WidthW  = 15;
   localparam int ScaleW  = 8;
   localparam int CsrIdxW = 8;
   localparam int GlyphW  = 6;

   localparam logic [ScaleW-1:0]  SCALE_X_RESET = 8'd1;
   localparam logic [ScaleW-1:0]  SCALE_Y_RESET = 8'd1;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_X   = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_SCALE_Y   = 8'd1;

   localparam logic [ByteW-1:0] END_BYTE = 8'h00;
   localparam logic [CpW-1:0]   CP_LF    = 21'h0A;
   localparam logic [CpW-1:0]   CP_CR    = 21'h0D;
   localparam logic [CpW-1:0]   CP_QMARK = 21'h3F;
   localparam logic [CpW-1:0]   CP_ASCII = 21'h80;

   localparam logic [WidthW-1:0] WIDTH_MAX = 15'h7FFF;

   typedef struct packed {
      logic [1:0]     pending;
      logic [CpW-1:0] partial;
   } dec_state_type;

   typedef struct packed {
      dec_state_type  next;
      logic           done;
      logic [CpW-1:0] cp;
   } dec_result_type;

   function automatic logic [GlyphW-1:0] glyph_size(input logic [ScaleW-1:0] scale_y);
      logic [GlyphW-1:0] g;
      if (scale_y <= 8'd1) begin
         g = 6'd12;
      end else if (scale_y == 8'd2) begin
         g = 6'd16;
      end else if (scale_y == 8'd3) begin
         g = 6'd24;
      end else begin
         g = 6'd32;
      end
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- sv/utf8_text_width_measure.sv -----
// Top level: UTF-8 text width measurement with input and result registers.
//
// Usage:
//   req_ carries one string byte per transfer (req_text_byte). A zero byte
//   ends the string; it produces one transfer on rsp_ with rsp_max_width,
//   the widest line in pixels, and clears the line state. Other bytes give
//   no result.
//   csr_ writes scale_x (index 0) and scale_y (index 1); other indexes are
//   ignored. csr_ready is always high. Write only while the block is idle.
// Order: a byte is registered in the input register on acceptance and
//   processed from it; a processed end byte then loads the result register.
// Throughput: one byte per cycle unless an end byte waits on a held result,
//   set by the single decode and width update stage between the input and state registers.
// Reset: clears decode state, widths and the valid flags of both pipeline
//   registers, and sets both scales to 1.
// Stall: an end byte waits in the input register while a previous result is
//   held; req_ready drops only when both registers are full.
`default_nettype none

module utf8_text_width_measure (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [utm_pkg::ByteW-1:0]    req_text_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [utm_pkg::WidthW-1:0]   rsp_max_width,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [utm_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [utm_pkg::ScaleW-1:0]   csr_data
);

   logic                         in_valid_ff, in_valid_in;
   logic [utm_pkg::ByteW-1:0]    byte_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [utm_pkg::WidthW-1:0]   width_ff;
   logic [utm_pkg::ScaleW-1:0]   scale_x_ff, scale_y_ff;
   logic [utm_pkg::WidthW-1:0]   end_width;
   logic                         is_end;
   logic                         step_en;
   logic                         req_fire;

   assign is_end    = (byte_ff == utm_pkg::END_BYTE);
   assign step_en   = in_valid_ff && (!is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_width = width_ff;

   utm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .text_byte (byte_ff),
      .scale_x   (scale_x_ff),
      .scale_y   (scale_y_ff),
      .end_width (end_width)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step_en) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_en && is_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scale_x_ff   <= utm_pkg::SCALE_X_RESET;
         scale_y_ff   <= utm_pkg::SCALE_Y_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == utm_pkg::CSR_SCALE_X) begin
               scale_x_ff <= csr_data;
            end else if (csr_index == utm_pkg::CSR_SCALE_Y) begin
               scale_y_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_text_byte;
      end
      if (step_en && is_end) begin
         width_ff <= end_width;
      end
   end

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && is_end)
      else $error("input stalled without a held end byte and result");

   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(byte_ff))
      else $error("unprocessed byte overwritten");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_en && is_end))
      else $error("result raised without an end byte");

endmodule

`default_nettype wire

// ----- sv/utm_decode.sv -----
// UTF-8 byte decoder: one byte against the pending sequence state.
`default_nettype none

module utm_decode (
   input  wire logic [utm_pkg::ByteW-1:0] text_byte,
   input  wire utm_pkg::dec_state_type    cur,
   output utm_pkg::dec_result_type        res
);

   always_comb begin
      res.next    = cur;
      res.done    = 1'b0;
      res.cp      = '0;
      if (cur.pending == 2'd0) begin
         if (text_byte[7] == 1'b0) begin
            res.done         = 1'b1;
            res.cp           = {13'd0, text_byte};
            res.next.partial = '0;
         end else if ((text_byte & 8'hE0) == 8'hC0) begin
            res.next.partial = {16'd0, text_byte[4:0]};
            res.next.pending = 2'd1;
         end else if ((text_byte & 8'hF0) == 8'hE0) begin
            res.next.partial = {17'd0, text_byte[3:0]};
            res.next.pending = 2'd2;
         end else if ((text_byte & 8'hF8) == 8'hF0) begin
            res.next.partial = {18'd0, text_byte[2:0]};
            res.next.pending = 2'd3;
         end else begin
            res.done         = 1'b1;
            res.cp           = utm_pkg::CP_QMARK;
            res.next.partial = '0;
         end
      end else if ((text_byte & 8'hC0) != 8'h80) begin
         res.done         = 1'b1;
         res.cp           = utm_pkg::CP_QMARK;
         res.next.pending = 2'd0;
         res.next.partial = '0;
      end else begin
         res.cp           = {cur.partial[14:0], text_byte[5:0]};
         res.next.pending = cur.pending - 2'd1;
         res.done         = (cur.pending == 2'd1);
         res.next.partial = res.done ? '0 : res.cp;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utm_core.sv -----
// Decode state and line width tracking, one byte per enabled cycle.
`default_nettype none

module utm_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step_en,
   input  wire logic [utm_pkg::ByteW-1:0]   text_byte,
   input  wire logic [utm_pkg::ScaleW-1:0]  scale_x,
   input  wire logic [utm_pkg::ScaleW-1:0]  scale_y,
   output logic      [utm_pkg::WidthW-1:0]  end_width
);

   utm_pkg::dec_state_type  dec_ff, dec_in;
   utm_pkg::dec_result_type dec;
   logic [utm_pkg::WidthW-1:0] line_ff, line_in;
   logic [utm_pkg::WidthW-1:0] widest_ff, widest_in;
   logic [10:0]                ascii_add;
   logic [10:0]                add;
   logic [15:0]                sum;
   logic                       is_end;

   utm_decode u_decode (
      .text_byte (text_byte),
      .cur       (dec_ff),
      .res       (dec)
   );

   assign is_end    = (text_byte == utm_pkg::END_BYTE);
   assign end_width = (line_ff > widest_ff) ? line_ff : widest_ff;
   assign ascii_add = {1'b0, scale_x, 2'b00} + {2'b00, scale_x, 1'b0};
   assign add       = (dec.cp < utm_pkg::CP_ASCII) ? ascii_add
                                                    : {5'd0, utm_pkg::glyph_size(scale_y)};
   assign sum       = {1'b0, line_ff} + {5'd0, add};

   always_comb begin
      dec_in    = dec_ff;
      line_in   = line_ff;
      widest_in = widest_ff;
      if (step_en) begin
         if (is_end) begin
            dec_in    = '0;
            line_in   = '0;
            widest_in = '0;
         end else begin
            dec_in = dec.next;
            if (dec.done) begin
               if (dec.cp == utm_pkg::CP_LF) begin
                  widest_in = end_width;
                  line_in   = '0;
               end else if (dec.cp != utm_pkg::CP_CR) begin
                  line_in = sum[15] ? utm_pkg::WIDTH_MAX : sum[14:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff    <= '0;
         line_ff   <= '0;
         widest_ff <= '0;
      end else begin
         dec_ff    <= dec_in;
         line_ff   <= line_in;
         widest_ff <= widest_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && is_end |=> line_ff == '0 && widest_ff == '0 && dec_ff.pending == 2'd0)
      else $error("state not cleared after end of string");

   a_widest_grows: assert property (@(posedge clock) disable iff (reset)
      step_en && !is_end |=> widest_ff >= $past(widest_ff))
      else $error("widest line shrank within a string");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && !is_end && dec.done |=> dec_ff.pending == 2'd0 && dec_ff.partial == '0)
      else $error("decoder left a sequence pending after a codepoint");

endmodule

`default_nettype wire

// ----- tb/sv/utm_checker.sv -----
// Checker for the UTF-8 text width block: tracks transfers, predicts widths, compares results.
`timescale 1ns / 1ps

module utm_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [utm_pkg::ByteW-1:0]   req_text_byte,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [utm_pkg::WidthW-1:0]  rsp_max_width,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [utm_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [utm_pkg::ScaleW-1:0]  csr_data,
   output int                               fail_count,
   output int                               results_waiting
);

   localparam int ByteW  = utm_pkg::ByteW;
   localparam int CpW    = utm_pkg::CpW;
   localparam int WidthW = utm_pkg::WidthW;
   localparam int ScaleW = utm_pkg::ScaleW;

   typedef struct packed {
      logic [1:0]        pending;
      logic [CpW-1:0]    partial;
      logic [WidthW-1:0] line;
      logic [WidthW-1:0] widest;
   } width_state_type;

   width_state_type   text_state;
   logic [ScaleW-1:0] scale_x;
   logic [ScaleW-1:0] scale_y;
   logic [WidthW-1:0] widths_due [$];

   // Advances the decode and width state by one byte; ends is set for the end byte.
   function automatic width_state_type next_width_state(
      input  width_state_type   s,
      input  logic [ByteW-1:0]  b,
      input  logic [ScaleW-1:0] sx,
      input  logic [ScaleW-1:0] sy,
      output logic              ends,
      output logic [WidthW-1:0] width_out
   );
      width_state_type n;
      logic            done;
      logic [CpW-1:0]  cp;
      int              add;
      int              sum;
      n         = s;
      done      = 1'b0;
      cp        = '0;
      ends      = 1'b0;
      width_out = '0;
      if (b == utm_pkg::END_BYTE) begin
         ends      = 1'b1;
         width_out = (s.line > s.widest) ? s.line : s.widest;
         n         = '0;
      end else begin
         if (s.pending == 2'd0) begin
            if (b < 8'h80) begin
               cp   = CpW'(b);
               done = 1'b1;
            end else if ((b & 8'hE0) == 8'hC0) begin
               n.partial = CpW'(b & 8'h1F);
               n.pending = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
               n.partial = CpW'(b & 8'h0F);
               n.pending = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
               n.partial = CpW'(b & 8'h07);
               n.pending = 2'd3;
            end else begin
               cp   = utm_pkg::CP_QMARK;
               done = 1'b1;
            end
         end else if ((b & 8'hC0) != 8'h80) begin
            cp        = utm_pkg::CP_QMARK;
            n.pending = 2'd0;
            done      = 1'b1;
         end else begin
            n.partial = {s.partial[CpW-7:0], b[5:0]};
            n.pending = s.pending - 2'd1;
            cp        = n.partial;
            done      = (n.pending == 2'd0);
         end
         if (done) begin
            if (cp == utm_pkg::CP_LF) begin
               if (n.line > n.widest) n.widest = n.line;
               n.line = '0;
            end else if (cp != utm_pkg::CP_CR) begin
               if (cp < utm_pkg::CP_ASCII) begin
                  add = 6 * int'(sx);
               end else if (sy <= 8'd1) begin
                  add = 12;
               end else if (sy == 8'd2) begin
                  add = 16;
               end else if (sy == 8'd3) begin
                  add = 24;
               end else begin
                  add = 32;
               end
               sum    = int'(n.line) + add;
               n.line = (sum > int'(utm_pkg::WIDTH_MAX)) ? utm_pkg::WIDTH_MAX
                                                          : WidthW'(sum);
            end
            n.partial = '0;
         end
      end
      return n;
   endfunction

   always @(posedge clock) begin
      logic              ends;
      logic [WidthW-1:0] width_out;
      logic [WidthW-1:0] due;
      if (reset) begin
         text_state <= '0;
         scale_x    <= utm_pkg::SCALE_X_RESET;
         scale_y    <= utm_pkg::SCALE_Y_RESET;
         widths_due.delete();
         fail_count      <= 0;
         results_waiting <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (widths_due.size() == 0) begin
               $error("unexpected result transfer: max_width %0d", rsp_max_width);
               fail_count <= fail_count + 1;
            end else begin
               due = widths_due.pop_front();
               if (rsp_max_width !== due) begin
                  $error("max_width: expected %0d, actual %0d", due, rsp_max_width);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            text_state <= next_width_state(text_state, req_text_byte, scale_x, scale_y,
                                           ends, width_out);
            if (ends) widths_due.push_back(width_out);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == utm_pkg::CSR_SCALE_X) scale_x <= csr_data;
            else if (csr_index == utm_pkg::CSR_SCALE_Y) scale_y <= csr_data;
         end
         results_waiting <= widths_due.size();
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top for the UTF-8 text width block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int ByteW   = utm_pkg::ByteW;
   localparam int WidthW  = utm_pkg::WidthW;
   localparam int ScaleW  = utm_pkg::ScaleW;
   localparam int CsrIdxW = utm_pkg::CsrIdxW;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 52;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [ByteW-1:0]   req_text_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [WidthW-1:0]  rsp_max_width;
   logic               csr_valid     = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index     = '0;
   logic [ScaleW-1:0]  csr_data      = '0;

   int fail_count;
   int results_waiting;
   int send_idle_pct = 17;
   int recv_idle_pct = 61;
   int items_sent    = 0;
   int quiet_cycles  = 0;

   always #5 clock = ~clock;

   utf8_text_width_measure dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_width (rsp_max_width),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   utm_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_max_width   (rsp_max_width),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .results_waiting (results_waiting)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL utf8_text_width_measure");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [ByteW-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Lead byte for a sequence of conts continuations, then sent_conts of them.
   task automatic send_utf8(input int conts, input int sent_conts);
      logic [ByteW-1:0] lead;
      case (conts)
         1:       lead = 8'hC0 | ByteW'($urandom_range(0, 31));
         2:       lead = 8'hE0 | ByteW'($urandom_range(0, 15));
         default: lead = 8'hF0 | ByteW'($urandom_range(0, 7));
      endcase
      send_byte(lead);
      for (int i = 0; i < sent_conts; i++) begin
         send_byte(8'h80 | ByteW'($urandom_range(0, 63)));
      end
   endtask

   task automatic send_random_text();
      int len;
      int kind;
      int conts;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      for (int i = 0; i < len; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_byte(ByteW'($urandom_range(1, 127)));
         end else if (kind < 48) begin
            send_byte(8'h0A);
         end else if (kind < 50) begin
            send_byte(8'h0D);
         end else if (kind < 80) begin
            conts = (kind < 62) ? 1 : (kind < 72) ? 2 : 3;
            send_utf8(conts, conts);
         end else if (kind < 90) begin
            conts = $urandom_range(1, 3);
            send_utf8(conts, $urandom_range(0, conts - 1));
         end else begin
            send_byte(ByteW'($urandom_range(1, 255)));
         end
      end
      if ($urandom_range(0, 9) != 0) send_byte(utm_pkg::END_BYTE);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [ScaleW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending, wait for every pending result, then let the pipeline empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [ByteW-1:0]  opening [0:27];
      logic [ScaleW-1:0] plan_x [0:8];
      logic [ScaleW-1:0] plan_y [0:8];
      // end-only, multibyte, bad leads, bad continuation, overlong LF/CR, end mid-sequence
      opening = '{8'h00, 8'h00,
                  8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00,
                  8'h80, 8'hFF, 8'hF8, 8'hC3, 8'h41, 8'h00,
                  8'hC0, 8'h8A, 8'h41, 8'h0A, 8'hC0, 8'h8D, 8'h0D, 8'h41, 8'hE2, 8'h82};
      plan_x = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd255, 8'd3, 8'd0, 8'd4, 8'd0};
      plan_y = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd1, 8'd0, 8'd4, 8'd0};
      plan_x[6] = ScaleW'($urandom_range(0, 255));
      plan_y[6] = ScaleW'($urandom_range(0, 255));
      plan_x[8] = ScaleW'($urandom_range(0, 255));
      plan_y[8] = ScaleW'($urandom_range(0, 255));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_byte(opening[i]);
      send_byte(utm_pkg::END_BYTE);

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 61 : 0;
         recv_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 17 : 0;
         for (int p = 0; p < 3; p++) begin
            drain_results();
            write_csr(utm_pkg::CSR_SCALE_X, plan_x[mode * 3 + p]);
            write_csr(utm_pkg::CSR_SCALE_Y, plan_y[mode * 3 + p]);
            if (p == 0) write_csr(8'hFF, 8'hFF);
            else if ($urandom_range(0, 1) == 1)
               write_csr(CsrIdxW'($urandom_range(2, 255)), ScaleW'($urandom_range(0, 255)));
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) send_random_text();
            send_byte(utm_pkg::END_BYTE);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS utf8_text_width_measure");
      end else begin
         $display("FAIL utf8_text_width_measure");
      end
      $finish;
   end

endmodule
